// File: hw/rtl/frame_histogram_and_focus_sum_unit_assert.svh
`ifndef FRAME_HISTOGRAM_AND_FOCUS_SUM_UNIT_ASSERT_SVH
`define FRAME_HISTOGRAM_AND_FOCUS_SUM_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FHFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FHFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fhfs_pkg.sv
`timescale 1ns / 1ps

package fhfs_pkg;

    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    localparam int PIX_W        = 8;
    localparam int BIN_IDX_W    = 8;
    localparam int BIN_CNT      = 256;
    localparam int BIN_W        = 25;
    localparam int FOCUS_W      = 33;

    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 64;
    localparam int OUT_BIN_LSB  = 0;
    localparam int OUT_FOCUS_LSB = BIN_W;
    localparam int OUT_DONE_BIT = BIN_W + FOCUS_W;
    localparam int OUT_PAD_W    = OUT_DATA_W - BIN_W - FOCUS_W - 1;

    localparam logic [BIN_W-1:0]   BIN_MAX   = {BIN_W{1'b1}};
    localparam logic [FOCUS_W-1:0] FOCUS_MAX = {FOCUS_W{1'b1}};

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_READ  = 1'b1
    } t_action;

    // one classified request handed from front to back
    typedef struct packed {
        t_action                action;
        logic [PIX_W-1:0]       pixel;
        logic [BIN_IDX_W-1:0]   bin;
        logic                   frame_start;
        logic                   add_right;
        logic                   add_down;
        logic                   frame_end;
        logic [PIX_W-1:0]       left_px;
        logic [PIX_W-1:0]       above_px;
    } t_work;

endpackage

// File: hw/rtl/fhfs_front.sv
`timescale 1ns / 1ps

module fhfs_front
    import fhfs_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [IN_DATA_W-1:0]  i_tdata,
    input  logic                  i_tuser,
    input  logic [QCNT_W-1:0]     i_q_count,
    output logic                  o_push,
    output t_work                 o_work
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    function automatic int dim_m1(input int v, input int hi);
        if (v < 2) return 1;
        else if (v > hi) return hi - 1;
        else return v - 1;
    endfunction

    logic [CW-1:0]    r_w_m1;
    logic [RW-1:0]    r_h_m1;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [PIX_W-1:0] r_left;
    logic             r_s1_valid;
    t_work            r_s1;
    logic [PIX_W-1:0] r_above;
    logic [PIX_W-1:0] r_row_mem [MAX_WIDTH];

    logic             accept;
    logic             is_pixel;
    logic             last_col;
    logic             last_row;
    logic [PIX_W-1:0] pix;
    t_work            work_in;

    // S1 always pushes in the cycle after accept, so reserve a slot for it
    assign o_tready = ({1'b0, i_q_count} + (QCNT_W+1)'(r_s1_valid))
                      < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept   = i_tvalid && o_tready;
    assign pix      = i_tdata[PIX_W-1:0];
    assign is_pixel = (t_action'(i_tuser) == ACT_PIXEL);
    assign last_col = (r_col >= r_w_m1);
    assign last_row = (r_row >= r_h_m1);

    always_comb begin
        n_col = last_col ? '0 : r_col + 1'b1;
        n_row = r_row;
        if (last_col) begin
            n_row = last_row ? '0 : r_row + 1'b1;
        end
    end

    always_comb begin
        work_in             = '0;
        work_in.action      = t_action'(i_tuser);
        work_in.pixel       = pix;
        work_in.bin         = i_tdata[PIX_W +: BIN_IDX_W];
        work_in.frame_start = is_pixel && (r_col == '0) && (r_row == '0);
        work_in.add_right   = is_pixel && (r_col != '0) && !last_row;
        work_in.add_down    = is_pixel && (r_row != '0) && !last_col;
        work_in.frame_end   = is_pixel && last_col && last_row;
        work_in.left_px     = r_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1     <= CW'(dim_m1(FRAME_WIDTH_RESET, MAX_WIDTH));
            r_h_m1     <= RW'(dim_m1(FRAME_HEIGHT_RESET, MAX_HEIGHT));
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_FRAME_WIDTH: begin
                        r_w_m1 <= CW'(dim_m1(int'(i_cfg_data), MAX_WIDTH));
                    end
                    REG_FRAME_HEIGHT: begin
                        r_h_m1 <= RW'(dim_m1(int'(i_cfg_data), MAX_HEIGHT));
                    end
                    default: begin
                    end
                endcase
            end
            r_s1_valid <= accept;
            if (accept && is_pixel) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= work_in;
        end
    end

    // line store, read-first: the old value is the pixel one row above
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above <= r_row_mem[r_col];
            if (is_pixel) begin
                r_row_mem[r_col] <= pix;
            end
        end
    end

    always_comb begin
        o_work          = r_s1;
        o_work.above_px = r_above;
    end

    assign o_push = r_s1_valid;

endmodule

// File: hw/rtl/fhfs_queue.sv
`timescale 1ns / 1ps

module fhfs_queue
    import fhfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_work             i_work,
    input  logic              i_pop,
    output logic              o_valid,
    output t_work             o_work,
    output logic [QCNT_W-1:0] o_count
);

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push_ok;
    logic              pop_ok;

    assign push_ok = i_push && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign pop_ok  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop_ok)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: hw/rtl/fhfs_back.sv
`timescale 1ns / 1ps

module fhfs_back
    import fhfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_work                 i_q_work,
    output logic                  o_q_pop,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [OUT_DATA_W-1:0] o_tdata
);

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    logic [BIN_W-1:0]     r_hist [BIN_CNT];
    logic [BIN_CNT-1:0]   r_valid;
    logic [BIN_W-1:0]     r_rd;
    logic                 r_b_valid;
    t_work                r_b;
    logic                 r_fwd_valid;
    logic [BIN_IDX_W-1:0] r_fwd_addr;
    logic [BIN_W-1:0]     r_fwd_val;
    logic [FOCUS_W-1:0]   r_acc;
    logic                 r_done;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out;

    logic                 b_done;
    logic                 pop;
    logic                 b_pixel;
    logic [BIN_IDX_W-1:0] q_addr;
    logic [BIN_IDX_W-1:0] b_addr;
    logic [BIN_W-1:0]     old_cnt;
    logic [BIN_W-1:0]     inc_cnt;
    logic [FOCUS_W-1:0]   base;
    logic [PIX_W-1:0]     d_right;
    logic [PIX_W-1:0]     d_down;
    logic [FOCUS_W:0]     sum;
    logic [FOCUS_W-1:0]   n_acc;
    logic                 n_done;

    assign b_done  = r_b_valid && (!r_out_valid || i_tready);
    assign pop     = i_q_valid && (!r_b_valid || b_done);
    assign o_q_pop = pop;

    assign q_addr  = (i_q_work.action == ACT_READ) ? i_q_work.bin : i_q_work.pixel;
    assign b_addr  = (r_b.action == ACT_READ) ? r_b.bin : r_b.pixel;
    assign b_pixel = (r_b.action == ACT_PIXEL);

    // last write may have landed after this bin was read
    always_comb begin
        if (b_pixel && r_b.frame_start) begin
            old_cnt = '0;
        end else if (r_fwd_valid && (r_fwd_addr == b_addr)) begin
            old_cnt = r_fwd_val;
        end else if (r_valid[b_addr]) begin
            old_cnt = r_rd;
        end else begin
            old_cnt = '0;
        end
        inc_cnt = (old_cnt == BIN_MAX) ? old_cnt : old_cnt + 1'b1;
    end

    always_comb begin
        base    = r_b.frame_start ? '0 : r_acc;
        d_right = r_b.add_right ? abs_diff(r_b.pixel, r_b.left_px) : '0;
        d_down  = r_b.add_down ? abs_diff(r_b.pixel, r_b.above_px) : '0;
        sum     = {1'b0, base} + (FOCUS_W+1)'(d_right) + (FOCUS_W+1)'(d_down);
        n_acc   = sum[FOCUS_W] ? FOCUS_MAX : sum[FOCUS_W-1:0];
        n_done  = r_b.frame_end || (!r_b.frame_start && r_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_acc       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_b_valid <= 1'b1;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end
            if (b_done && b_pixel) begin
                // new frame: all bins read as zero until written again
                if (r_b.frame_start) begin
                    r_valid <= BIN_CNT'(1) << b_addr;
                end else begin
                    r_valid[b_addr] <= 1'b1;
                end
                r_fwd_valid     <= 1'b1;
                r_acc           <= n_acc;
                r_done          <= n_done;
            end
            if (b_done) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b <= i_q_work;
        end
        if (b_done && b_pixel) begin
            r_fwd_addr <= b_addr;
            r_fwd_val  <= inc_cnt;
        end
        if (b_done) begin
            if (b_pixel) begin
                r_out <= {{OUT_PAD_W{1'b0}}, n_done, n_acc, {BIN_W{1'b0}}};
            end else begin
                r_out <= {{OUT_PAD_W{1'b0}}, r_done, r_acc, old_cnt};
            end
        end
    end

    // histogram memory, read-first
    always_ff @(posedge i_clk) begin
        if (b_done && b_pixel) begin
            r_hist[b_addr] <= inc_cnt;
        end
        if (pop) begin
            r_rd <= r_hist[q_addr];
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out;

endmodule

// File: hw/rtl/frame_histogram_and_focus_sum_unit.sv
`timescale 1ns / 1ps
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: action; tdata: pixel_value, bin_index
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: bin_count, focus_sum, frame_done
// cfg       in   i_cfg_wr_en (no wait)          i_cfg_index, i_cfg_data
//
// one request per cycle sustained while m_axis accepts, pixel or read; an accepted request
// reaches m_axis_tvalid through line store read, queue, histogram read and output reg
// the histogram bin read-modify-write in the back part sets the pace
// on reset, bins are marked empty by flags, no clearing pass
// a stalled m_axis fills output reg, back stage and the four-entry queue, then
// s_axis_tready drops

module frame_histogram_and_focus_sum_unit
    import fhfs_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pixel_value[7:0], bin_index[15:8]
    input  logic                  s_axis_tuser,   // action[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // bin_count[24:0], focus_sum[57:25],
                                                  // frame_done[58], zero[63:59]
);

    logic              push;
    t_work             push_work;
    logic              q_valid;
    t_work             q_work;
    logic              q_pop;
    logic [QCNT_W-1:0] q_count;

    fhfs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_work      (push_work)
    );

    fhfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_work  (q_work),
        .o_count (q_count)
    );

    fhfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_work  (q_work),
        .o_q_pop   (q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata)
    );

endmodule

// File: hw/rtl/fhfs_port_checker.sv
`timescale 1ns / 1ps
`include "frame_histogram_and_focus_sum_unit_assert.svh"

module fhfs_port_checker
    import fhfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic               out_acc;
    logic [FOCUS_W-1:0] cur_focus;
    logic               cur_done;
    logic               r_prev_valid;
    logic [FOCUS_W-1:0] r_prev_focus;
    logic               r_prev_done;

    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign cur_focus = m_axis_tdata[OUT_FOCUS_LSB +: FOCUS_W];
    assign cur_done  = m_axis_tdata[OUT_DONE_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
        end else if (out_acc) begin
            r_prev_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev_focus <= cur_focus;
            r_prev_done  <= cur_done;
        end
    end

    `FHFS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `FHFS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "stalled result changed")
    `FHFS_ASSERT_NOW(a_focus_grows, out_acc && r_prev_valid && !r_prev_done && !cur_done, cur_focus >= r_prev_focus, "focus sum fell within a frame")
    `FHFS_ASSERT_NOW(a_focus_frozen, out_acc && r_prev_valid && r_prev_done && cur_done, cur_focus == r_prev_focus, "focus sum moved after frame end")

endmodule

bind frame_histogram_and_focus_sum_unit fhfs_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
